// ----- hdl/fcr_pkg.sv -----
// Shared types and constants for the flow cache row (move-to-front set).
// Request/response payload structs and command codes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fcr_pkg;

   localparam int CMD_W        = 3;
   localparam int FLOW_HASH_W  = 64;
   localparam int INDEX_W      = 3;
   localparam int HANDLE_IN_W  = 16;
   localparam int SLOT_INDEX_W = 3;
   localparam int HANDLE_OUT_W = 16;

   localparam logic [CMD_W-1:0] CMD_FIND_HASH   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_FIND_EMPTY  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_MOVE        = 3'd2;
   localparam logic [CMD_W-1:0] CMD_FIND_VICTIM = 3'd3;
   localparam logic [CMD_W-1:0] CMD_WRITE       = 3'd4;

   typedef struct packed {
      logic [CMD_W-1:0]       cmd;
      logic [FLOW_HASH_W-1:0] flow_hash;
      logic [INDEX_W-1:0]     from_index;
      logic [INDEX_W-1:0]     to_index;
      logic [HANDLE_IN_W-1:0] handle_in;
      logic                   valid_in;
      logic                   pinned_in;
   } req_type;

   typedef struct packed {
      logic                    found;
      logic [SLOT_INDEX_W-1:0] slot_index;
      logic [HANDLE_OUT_W-1:0] handle_out;
   } rsp_type;

endpackage

`default_nettype wire

// ----- hdl/fcr_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module fcr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hdl/flow_cache_row_mtf.sv -----
// One row (set) of a flow cache with move-to-front ordering. The row holds
// ROW_SIZE ordered slots (valid, 64-bit flow hash, record handle, pinned flag);
// hash and handle sit in a small RAM, the per-slot flags in flip-flops that
// reset clears, plus a "written" flag so that a never-written slot reads as
// zero. One request is worked at a time: req_stall is high from the cycle
// after acceptance until the response is loaded into the output register.
// A single slot read port and one 64-bit comparator are stepped over the slots
// by a small sequencer, one slot per cycle. A write, an unused code or a move
// that does nothing goes straight to the response; find hash / find empty /
// find victim visit the slots in turn (at most ROW_SIZE), and a move lifts the
// from_index slot, shifts each slot between it and to_index by one position
// and puts the lifted slot at to_index. While rsp_stall holds an earlier
// response in the output register, the finished request waits in the last
// sequencer state.
// Depends on fcr_pkg and fcr_ram.
`timescale 1ns / 1ps
`default_nettype none

module flow_cache_row_mtf
   import fcr_pkg::*;
#(
   parameter int ROW_SIZE    = 8,
   parameter int HANDLE_BITS = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   // request channel
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   // response channel
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int IDX_W  = $clog2(ROW_SIZE);
   // only the low bits that fit the 16-bit response field are ever seen
   localparam int HDL_W  = (HANDLE_BITS < HANDLE_OUT_W) ? HANDLE_BITS : HANDLE_OUT_W;
   localparam int WORD_W = FLOW_HASH_W + HDL_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ROW_SIZE - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MV_HOLD,
      ST_MV_SHIFT,
      ST_MV_PUT,
      ST_PUSH
   } state_type;

   // sequencer state
   state_type          state_ff, state_in;
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [FLOW_HASH_W-1:0] key_ff, key_in;
   logic [IDX_W-1:0]   cur_ff, cur_in;      // slot being worked; during a scan its data is on the RAM output
   logic [IDX_W-1:0]   to_ff, to_in;
   logic               up_ff, up_in;        // move toward higher positions
   // slot lifted out during a move
   logic [WORD_W-1:0]  hold_word_ff, hold_word_in;
   logic               hold_valid_ff, hold_valid_in;
   logic               hold_pinned_ff, hold_pinned_in;
   logic               hold_init_ff, hold_init_in;
   logic [HDL_W-1:0]   victim_hdl_ff, victim_hdl_in;
   // result waiting for the output register, and the output register
   rsp_type            res_ff, res_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   // per-slot flags
   logic [ROW_SIZE-1:0] valid_ff, valid_in;
   logic [ROW_SIZE-1:0] pinned_ff, pinned_in;
   logic [ROW_SIZE-1:0] init_ff, init_in;

   // RAM port
   logic               ram_we;
   logic [IDX_W-1:0]   ram_wr_addr;
   logic [WORD_W-1:0]  ram_wr_data;
   logic [IDX_W-1:0]   ram_rd_addr;
   logic [WORD_W-1:0]  ram_rd_data;

   // flag write port
   logic               flag_we;
   logic [IDX_W-1:0]   flag_addr;
   logic               flag_v, flag_p, flag_i;

   logic               accept;
   logic               from_ok, to_ok;
   logic [IDX_W-1:0]   from_w, to_w;
   logic [IDX_W-1:0]   src_idx, nxt_src;
   logic [FLOW_HASH_W-1:0] rd_hash;
   logic [HDL_W-1:0]   rd_hdl;
   logic               hit, last;
   logic [IDX_W-1:0]   scan_nxt;

   fcr_ram #(
      .WIDTH (WORD_W),
      .DEPTH (ROW_SIZE)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign from_ok = int'(req_data.from_index) < ROW_SIZE;
   assign to_ok   = int'(req_data.to_index) < ROW_SIZE;
   assign from_w  = IDX_W'(req_data.from_index);
   assign to_w    = IDX_W'(req_data.to_index);

   // neighbor that shifts into the current position during a move
   assign src_idx = up_ff ? cur_ff + 1'b1 : cur_ff - 1'b1;
   assign nxt_src = up_ff ? src_idx + 1'b1 : src_idx - 1'b1;

   // never-written slots read as zero
   assign rd_hash = init_ff[cur_ff] ? ram_rd_data[WORD_W-1 -: FLOW_HASH_W] : '0;
   assign rd_hdl  = init_ff[cur_ff] ? ram_rd_data[HDL_W-1:0] : '0;

   // the shared comparator: one slot per cycle
   always_comb begin
      unique case (cmd_ff)
         CMD_FIND_HASH:  hit = valid_ff[cur_ff] && (rd_hash == key_ff);
         CMD_FIND_EMPTY: hit = !valid_ff[cur_ff];
         default:        hit = !pinned_ff[cur_ff];
      endcase
   end

   // victim search walks down from the last slot, the others walk up
   assign last     = (cmd_ff == CMD_FIND_VICTIM) ? (cur_ff == '0) : (cur_ff == LAST_IDX);
   assign scan_nxt = (cmd_ff == CMD_FIND_VICTIM) ? cur_ff - 1'b1 : cur_ff + 1'b1;

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      key_in         = key_ff;
      cur_in         = cur_ff;
      to_in          = to_ff;
      up_in          = up_ff;
      hold_word_in   = hold_word_ff;
      hold_valid_in  = hold_valid_ff;
      hold_pinned_in = hold_pinned_ff;
      hold_init_in   = hold_init_ff;
      victim_hdl_in  = victim_hdl_ff;
      res_in         = res_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff;

      ram_we      = 1'b0;
      ram_wr_addr = cur_ff;
      ram_wr_data = ram_rd_data;
      ram_rd_addr = cur_ff;

      flag_we   = 1'b0;
      flag_addr = cur_ff;
      flag_v    = 1'b0;
      flag_p    = 1'b0;
      flag_i    = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in = req_data.cmd;
               key_in = req_data.flow_hash;
               res_in = '{found: 1'b1, slot_index: '0, handle_out: '0};
               unique case (req_data.cmd)
                  CMD_FIND_HASH, CMD_FIND_EMPTY: begin
                     cur_in      = '0;
                     ram_rd_addr = '0;
                     state_in    = ST_SCAN;
                  end
                  CMD_FIND_VICTIM: begin
                     cur_in      = LAST_IDX;
                     ram_rd_addr = LAST_IDX;
                     state_in    = ST_SCAN;
                  end
                  CMD_MOVE: begin
                     if (from_ok && to_ok && (req_data.from_index != req_data.to_index)) begin
                        cur_in      = from_w;
                        to_in       = to_w;
                        up_in       = req_data.from_index < req_data.to_index;
                        ram_rd_addr = from_w;
                        state_in    = ST_MV_HOLD;
                     end else begin
                        state_in = ST_PUSH;
                     end
                  end
                  CMD_WRITE: begin
                     if (from_ok) begin
                        ram_we      = 1'b1;
                        ram_wr_addr = from_w;
                        ram_wr_data = {req_data.flow_hash, req_data.handle_in[HDL_W-1:0]};
                        flag_we     = 1'b1;
                        flag_addr   = from_w;
                        flag_v      = req_data.valid_in;
                        flag_p      = req_data.pinned_in;
                        flag_i      = 1'b1;
                     end
                     state_in = ST_PUSH;
                  end
                  default: begin
                     res_in   = '{found: 1'b0, slot_index: '0, handle_out: '0};
                     state_in = ST_PUSH;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (cur_ff == LAST_IDX) begin
               victim_hdl_in = rd_hdl;
            end
            if (hit) begin
               res_in = '{found: 1'b1, slot_index: SLOT_INDEX_W'(cur_ff),
                          handle_out: HANDLE_OUT_W'(rd_hdl)};
               state_in = ST_PUSH;
            end else if (last) begin
               if (cmd_ff == CMD_FIND_VICTIM) begin
                  // every slot pinned: the last slot goes
                  res_in = '{found: 1'b1, slot_index: SLOT_INDEX_W'(LAST_IDX),
                             handle_out: HANDLE_OUT_W'(victim_hdl_ff)};
               end else begin
                  res_in = '{found: 1'b0, slot_index: '0, handle_out: '0};
               end
               state_in = ST_PUSH;
            end else begin
               cur_in      = scan_nxt;
               ram_rd_addr = scan_nxt;
            end
         end

         ST_MV_HOLD: begin
            hold_word_in   = ram_rd_data;
            hold_valid_in  = valid_ff[cur_ff];
            hold_pinned_in = pinned_ff[cur_ff];
            hold_init_in   = init_ff[cur_ff];
            ram_rd_addr    = src_idx;
            state_in       = ST_MV_SHIFT;
         end

         ST_MV_SHIFT: begin
            // neighbor's data is on the RAM output; copy it into cur
            ram_we      = 1'b1;
            ram_wr_addr = cur_ff;
            ram_wr_data = ram_rd_data;
            flag_we     = 1'b1;
            flag_addr   = cur_ff;
            flag_v      = valid_ff[src_idx];
            flag_p      = pinned_ff[src_idx];
            flag_i      = init_ff[src_idx];
            cur_in      = src_idx;
            if (src_idx == to_ff) begin
               state_in = ST_MV_PUT;
            end else begin
               ram_rd_addr = nxt_src;
            end
         end

         ST_MV_PUT: begin
            ram_we      = 1'b1;
            ram_wr_addr = to_ff;
            ram_wr_data = hold_word_ff;
            flag_we     = 1'b1;
            flag_addr   = to_ff;
            flag_v      = hold_valid_ff;
            flag_p      = hold_pinned_ff;
            flag_i      = hold_init_ff;
            state_in    = ST_PUSH;
         end

         ST_PUSH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      valid_in  = valid_ff;
      pinned_in = pinned_ff;
      init_in   = init_ff;
      if (flag_we) begin
         valid_in[flag_addr]  = flag_v;
         pinned_in[flag_addr] = flag_p;
         init_in[flag_addr]   = flag_i;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      key_ff         <= key_in;
      cur_ff         <= cur_in;
      to_ff          <= to_in;
      up_ff          <= up_in;
      hold_word_ff   <= hold_word_in;
      hold_valid_ff  <= hold_valid_in;
      hold_pinned_ff <= hold_pinned_in;
      hold_init_ff   <= hold_init_in;
      victim_hdl_ff  <= victim_hdl_in;
      res_ff         <= res_in;
      rsp_ff         <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         pinned_ff    <= '0;
         init_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
         pinned_ff    <= pinned_in;
         init_ff      <= init_in;
      end
   end

endmodule

`default_nettype wire
